[rtl/sfir_pkg.sv]
// sfir_pkg: shared constants, types and the coefficient table of the stereo fir filter
// no dependencies; compiled first
`timescale 1ns / 1ps

package sfir_pkg;

  localparam int TAP_COUNT      = 25;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 15;
  // all coefficients stay below one half in magnitude, so one integer bit is enough
  localparam int COEF_BITS      = COEF_FRAC_BITS + 1;
  localparam int TAP_BITS       = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS       = PROD_BITS + TAP_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FIN
  } seq_state_t;

  // per-lane control issued by the sequencer
  typedef struct packed {
    logic                shift;
    logic                clear;
    logic                mac;
    logic [TAP_BITS-1:0] tap;
  } lane_ctl_t;

  // q1.15 tap weights, taps 1..24 mirrored about taps 12/13, rescaled to COEF_FRAC_BITS
  function automatic logic signed [COEF_BITS-1:0] coef_at(input logic [TAP_BITS-1:0] k);
    int q;
    int ki;
    ki = int'(k);
    case (ki)
      0:       q = 121;
      1:       q = 425;
      2:       q = 109;
      3:       q = 599;
      4:       q = 658;
      5:       q = -585;
      6:       q = 540;
      7:       q = -1029;
      8:       q = -3168;
      9:       q = -85;
      10:      q = -5762;
      11:      q = -6054;
      12:      q = 14292;
      13:      q = 14292;
      14:      q = -6054;
      15:      q = -5762;
      16:      q = -85;
      17:      q = -3168;
      18:      q = -1029;
      19:      q = 540;
      20:      q = -585;
      21:      q = 658;
      22:      q = 599;
      23:      q = 109;
      24:      q = 425;
      default: q = 0;
    endcase
    if (COEF_FRAC_BITS >= 15) begin
      q = q <<< (COEF_FRAC_BITS - 15);
    end else begin
      q = q >>> (15 - COEF_FRAC_BITS);
    end
    return COEF_BITS'(q);
  endfunction

endpackage

[rtl/sfir_if.sv]
// sfir_in_if / sfir_out_if: valid-ready channels carrying stereo sample pairs
// depends on sfir_pkg for the sample width
`timescale 1ns / 1ps

interface sfir_in_if import sfir_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface sfir_out_if import sfir_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_filtered;
  logic signed [SAMPLE_BITS-1:0] right_filtered;

  modport source (output valid, output left_filtered, output right_filtered, input ready);
  modport sink   (input valid, input left_filtered, input right_filtered, output ready);
endinterface

[rtl/sfir_lane.sv]
// sfir_lane: one channel's delay line, shared multiply-accumulate and output rounding
// depends on sfir_pkg
`timescale 1ns / 1ps

module sfir_lane import sfir_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lane_ctl_t                     ctl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam logic signed [ACC_BITS-1:0] SAT_MAX  = ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS-1:0] SAT_MIN  = -SAT_MAX - ACC_BITS'(1);
  localparam logic signed [ACC_BITS-1:0] TRUNC_BIAS = ACC_BITS'((64'sd1 <<< COEF_FRAC_BITS) - 1);

  logic signed [SAMPLE_BITS-1:0] hist_r [TAP_COUNT];
  logic signed [ACC_BITS-1:0]    acc_r;
  logic signed [ACC_BITS-1:0]    acc_nxt;
  logic signed [SAMPLE_BITS-1:0] tap_sample;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [ACC_BITS-1:0]    biased;
  logic signed [ACC_BITS-1:0]    quot;

  // newest sample at index 0, index k is k items old
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAP_COUNT; i++) begin
        hist_r[i] <= '0;
      end
    end else if (ctl.shift) begin
      hist_r[0] <= sample;
      for (int i = 1; i < TAP_COUNT; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  assign tap_sample = hist_r[ctl.tap];
  assign prod       = tap_sample * coef_at(ctl.tap);

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.mac) begin
      acc_nxt = acc_r + ACC_BITS'(prod);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // truncate toward zero, then saturate
  assign biased = acc_r[ACC_BITS-1] ? (acc_r + TRUNC_BIAS) : acc_r;
  assign quot   = biased >>> COEF_FRAC_BITS;

  always_comb begin
    if (quot > SAT_MAX) begin
      result = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (quot < SAT_MIN) begin
      result = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      result = quot[SAMPLE_BITS-1:0];
    end
  end

endmodule

[rtl/sfir_ctrl.sv]
// sfir_ctrl: sequencer stepping both lanes through the taps of one item
// depends on sfir_pkg
`timescale 1ns / 1ps

module sfir_ctrl import sfir_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_free,
  output logic      in_ready,
  output logic      load,
  output lane_ctl_t ctl
);

  localparam logic [TAP_BITS-1:0] LAST_TAP = TAP_BITS'(TAP_COUNT - 1);

  seq_state_t          state_r;
  seq_state_t          state_nxt;
  logic [TAP_BITS-1:0] tap_r;
  logic [TAP_BITS-1:0] tap_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    in_ready  = 1'b0;
    load      = 1'b0;
    ctl       = '0;
    ctl.tap   = tap_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.shift = 1'b1;
          ctl.clear = 1'b1;
          tap_nxt   = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        ctl.mac = 1'b1;
        if (tap_r == LAST_TAP) begin
          state_nxt = ST_FIN;
        end else begin
          tap_nxt = tap_r + TAP_BITS'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/stereo_fir_filter_25tap.sv]
// stereo_fir_filter_25tap: top level, two filter lanes, sequencer and output register
// depends on sfir_pkg, sfir_if, sfir_lane and sfir_ctrl
`timescale 1ns / 1ps

// usage
//   in_ch carries one stereo pair (left_sample, right_sample) per transfer,
//   out_ch returns one filtered pair (left_filtered, right_filtered) per input.
//   both channels are valid/ready; a transfer happens when both are high.
// timing
//   after an input transfer the two lanes run their 25 taps in parallel, one
//   tap per cycle through one multiplier per lane; the sum is truncated and
//   saturated in the final step and loaded into the output register once it
//   is free; out_ch.valid rises with that load.
//   in_ch.ready is high only while the sequencer is idle, so a new pair is
//   not accepted until the previous one has been loaded for output.
// stall
//   the output register holds a finished pair while out_ch.ready is low; the
//   next item may be accepted and filtered meanwhile, and waits in the final
//   step until the register frees up. nothing is dropped.
// reset
//   rst_n is synchronous, active low: delay lines clear to zero, the sequencer
//   goes idle and the output register is emptied.
module stereo_fir_filter_25tap import sfir_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sfir_in_if.sink     in_ch,
  sfir_out_if.source  out_ch
);

  lane_ctl_t                     ctl;
  logic                          load;
  logic                          out_free;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_res;
  logic signed [SAMPLE_BITS-1:0] right_res;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] left_out_r;
  logic signed [SAMPLE_BITS-1:0] right_out_r;

  // output slot can take a new pair when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ch.ready;

  sfir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .in_ready (ready),
    .load     (load),
    .ctl      (ctl)
  );

  assign in_ch.ready = ready;

  // both lanes share the same tap sequence
  sfir_lane u_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_ch.left_sample),
    .result (left_res)
  );

  sfir_lane u_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_ch.right_sample),
    .result (right_res)
  );

  // merge the two lane results into one output pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_out_r  <= left_res;
      right_out_r <= right_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.left_filtered  = left_out_r;
  assign out_ch.right_filtered = right_out_r;

endmodule

[tb/tb_stereo_fir_filter_25tap.sv]
// tb_stereo_fir_filter_25tap: self-checking bench for the stereo 25-tap fir filter
// depends on sfir_pkg, sfir_if and the stereo_fir_filter_25tap rtl
// a scoreboard class predicts each filtered pair; valid/ready traffic is randomized on both sides
`timescale 1ns / 1ps

module tb_stereo_fir_filter_25tap;
  import sfir_pkg::*;

  localparam int RANDOM_ITEMS = 1830;  // plus the directed pairs, about 1850 in all
  localparam int LONG_HOLD    = 400;   // receiver hold-off, long enough to back up the input
  localparam int TAIL_CYCLES  = 60;    // settle time after the last expected pair

  // q1.15 tap weights, tap k multiplies the sample that is k transfers old
  localparam int TAP_WEIGHT [TAP_COUNT] = '{
    121, 425, 109, 599, 658, -585, 540, -1029, -3168, -85,
    -5762, -6054, 14292, 14292, -6054, -5762, -85, -3168, -1029, 540,
    -585, 658, 599, 109, 425
  };

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_pair_t;

  // keeps its own copy of both delay lines and queues the filtered pairs still owed
  class pair_scoreboard;
    sample_t      left_line [TAP_COUNT];
    sample_t      right_line [TAP_COUNT];
    int unsigned  head;
    stereo_pair_t filtered_q [$];
    int unsigned  errors;

    function new();
      foreach (left_line[i]) begin
        left_line[i]  = '0;
        right_line[i] = '0;
      end
      head   = 0;
      errors = 0;
    endfunction

    // divide by 2^COEF_FRAC_BITS toward zero, then clamp to the sample range
    function sample_t clip_sum(longint acc);
      longint q;
      longint top;
      top = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
      q   = acc / (longint'(1) << COEF_FRAC_BITS);
      if (q > top) begin
        q = top;
      end
      if (q < -top - 1) begin
        q = -top - 1;
      end
      return sample_t'(q);
    endfunction

    // an input pair was transferred: shift it in and predict the filtered pair
    function void take_pair(sample_t l, sample_t r);
      longint       acc_l;
      longint       acc_r;
      int unsigned  idx;
      stereo_pair_t want;
      acc_l = 0;
      acc_r = 0;
      head  = (head == 0) ? TAP_COUNT - 1 : head - 1;
      left_line[head]  = l;
      right_line[head] = r;
      idx = head;
      for (int k = 0; k < TAP_COUNT; k++) begin
        acc_l += longint'(TAP_WEIGHT[k]) * longint'(left_line[idx]);
        acc_r += longint'(TAP_WEIGHT[k]) * longint'(right_line[idx]);
        idx = (idx + 1 == TAP_COUNT) ? 0 : idx + 1;
      end
      want.left  = clip_sum(acc_l);
      want.right = clip_sum(acc_r);
      filtered_q.push_back(want);
    endfunction

    // a filtered pair was transferred out: compare against the oldest prediction
    function void check_filtered(sample_t l, sample_t r);
      stereo_pair_t want;
      if (filtered_q.size() == 0) begin
        $error("filtered pair with no input outstanding: left %0d right %0d", l, r);
        errors++;
        return;
      end
      want = filtered_q.pop_front();
      if (l !== want.left) begin
        $error("left_filtered mismatch: expected %0d, actual %0d", want.left, l);
        errors++;
      end
      if (r !== want.right) begin
        $error("right_filtered mismatch: expected %0d, actual %0d", want.right, r);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return filtered_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   hold_req;  // set by the sender side, served by the receiver process

  sfir_in_if  in_ch ();
  sfir_out_if out_ch ();

  pair_scoreboard sb = new();

  stereo_fir_filter_25tap dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall limit: a correct run needs well under 2 ms even with every stall at its longest
  initial begin
    #10_000_000;
    $display("FAIL stereo_fir_filter_25tap");
    $finish;
  end

  // result monitor, values sampled as they stood before the edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_filtered(out_ch.left_filtered, out_ch.right_filtered);
    end
  end

  // receiver: segments of always-ready, coin-flip, and stall-then-take patterns,
  // plus one long hold-off on request
  initial begin : receiver
    int unsigned seg;
    int unsigned len;
    int unsigned stall;
    logic        rdy;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        // hold off so the output register and the lane pipeline fill up and stall the input
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      seg   = $urandom_range(0, 3);
      len   = $urandom_range(5, 60);
      stall = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
        case (seg)
          0: begin
            rdy = 1'b1;
          end
          1: begin
            rdy = $urandom_range(0, 1);
          end
          2: begin
            rdy = ((i % 4) == 3);
          end
          default: begin
            // one ready cycle after a stall of random length
            rdy = ((i % (stall + 1)) == stall);
          end
        endcase
        out_ch.ready <= rdy;
        @(posedge clk);
      end
    end
  end

  // offer one pair and hold it until the transfer; valid is left high for a back-to-back caller
  task automatic offer_pair(input sample_t l, input sample_t r);
    in_ch.valid        <= 1'b1;
    in_ch.left_sample  <= l;
    in_ch.right_sample <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_pair(l, r);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // sender pause until every owed pair has come back
  task automatic drain_filtered();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic sample_t any_sample();
    return sample_t'($urandom_range(0, 65535));
  endfunction

  function automatic sample_t corner_sample();
    case ($urandom_range(0, 4))
      0:       return sample_t'(32767);
      1:       return sample_t'(-32768);
      2:       return sample_t'(0);
      3:       return sample_t'(-1);
      default: return sample_t'(1);
    endcase
  endfunction

  // main sender: reset, directed pairs, then random bursts
  initial begin : sender
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    int unsigned mag;
    bit          pol;
    bit          hold_done;
    bit          drain_done;
    sample_t     l;
    sample_t     r;
    sent       = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    hold_req   = 1'b0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.left_sample  <= '0;
    in_ch.right_sample <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: start-up from an empty line, impulses at both extremes, sign and bit patterns
    offer_pair(16'sd0, 16'sd0);
    offer_pair(16'sd32767, -16'sd32768);
    offer_pair(-16'sd32768, 16'sd32767);
    offer_pair(16'sd1, -16'sd1);
    offer_pair(-16'sd1, 16'sd1);
    offer_pair(16'sd32767, 16'sd32767);
    offer_pair(16'sd32767, 16'sd32767);
    offer_pair(-16'sd32768, -16'sd32768);
    offer_pair(-16'sd32768, -16'sd32768);
    offer_pair(sample_t'(16'h5555), sample_t'(16'hAAAA));
    offer_pair(sample_t'(16'hAAAA), sample_t'(16'h5555));
    offer_pair(16'sd16384, -16'sd16384);
    offer_pair(16'sd0, 16'sd0);
    drain_filtered();

    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind == 5 || kind == 6) begin
        // sign-matched run: the last pair of the run lines every tap up with its weight,
        // driving one channel into positive and the other into negative saturation
        pol = $urandom_range(0, 1);
        for (int j = 0; j < TAP_COUNT; j++) begin
          mag = $urandom_range(20000, 32767);
          l = ((TAP_WEIGHT[TAP_COUNT-1-j] > 0) ^ pol) ? sample_t'(mag) : sample_t'(-int'(mag));
          mag = $urandom_range(20000, 32767);
          r = ((TAP_WEIGHT[TAP_COUNT-1-j] > 0) ^ pol) ? sample_t'(-int'(mag)) : sample_t'(mag);
          offer_pair(l, r);
          sent++;
        end
      end else begin
        len = $urandom_range(1, 12);
        for (int j = 0; j < len; j++) begin
          case (kind)
            7: begin
              l = sample_t'($urandom_range(0, 128)) - 16'sd64;
              r = sample_t'($urandom_range(0, 128)) - 16'sd64;
            end
            8: begin
              l = corner_sample();
              r = corner_sample();
            end
            9: begin
              // one channel silent while the other runs
              l = $urandom_range(0, 1) ? any_sample() : '0;
              r = (l == 0) ? any_sample() : '0;
            end
            default: begin
              l = any_sample();
              r = any_sample();
            end
          endcase
          offer_pair(l, r);
          sent++;
        end
      end

      if (!hold_done && sent >= 600) begin
        // receiver goes quiet while this side keeps offering
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      if (!drain_done && sent >= 1200) begin
        drain_done = 1'b1;
        drain_filtered();
      end

      // gap between bursts, zero about a third of the time so valid stays high across them
      if ($urandom_range(0, 9) >= 3) begin
        idle_sender($urandom_range(1, 30));
      end
    end

    // wait out every owed pair, then leave room for anything spurious to show up
    drain_filtered();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS stereo_fir_filter_25tap");
    end else begin
      $display("FAIL stereo_fir_filter_25tap");
    end
    $finish;
  end

endmodule
